FILE: src/hdps_pkg.sv
package hdps_pkg;

	localparam int FRAME_MAX_DEF = 255;
	localparam int FRAME_ADDR_W_DEF = 8;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_PREP_TX = 3'd1;
	localparam logic [2:0] ACT_START_TX = 3'd2;
	localparam logic [2:0] ACT_PREP_RX = 3'd3;
	localparam logic [2:0] ACT_STOP_RX = 3'd4;
	localparam logic [2:0] ACT_FRAME_RDY = 3'd5;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_TURN = 3'd1;
	localparam logic [2:0] PH_SEND = 3'd2;
	localparam logic [2:0] PH_RECV = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	localparam logic [1:0] REG_SEND_PERIOD = 2'd0;
	localparam logic [1:0] REG_TURNAROUND = 2'd1;
	localparam logic [1:0] REG_BYTE_GAP = 2'd2;
	localparam logic [1:0] REG_NO_ANSWER = 2'd3;

	localparam logic [15:0] SEND_PERIOD_RST = 16'd500;
	localparam logic [15:0] TURNAROUND_RST = 16'd5;
	localparam logic [15:0] BYTE_GAP_RST = 16'd5;
	localparam logic [15:0] NO_ANSWER_RST = 16'd200;

	typedef struct packed {
		logic [1:0] op;
		logic [15:0] elapsed;
		logic have_data;
		logic tx_busy;
		logic [7:0] rx_data;
		logic [7:0] read_index;
	} req_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] frame_length;
		logic [7:0] read_data;
		logic [2:0] phase;
	} rsp_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hffff : s[15:0];
	endfunction

endpackage

FILE: src/half_duplex_serial_poll_sequencer.sv
// Channel   Handshake              Payload
// cfg       cfg_we                 cfg_index, cfg_data
// request   req_valid / req_ready  req (hdps_pkg::req_t)
// response  rsp_valid / rsp_ready  rsp (hdps_pkg::rsp_t)
//
// A request goes through the first stage, then the output register; one
// request is accepted every cycle unless both stages are full and rsp_ready is low.
// Reset clears the phase machine, the counters and the pipeline valid bits.
// A stalled response holds in the output register while one more request
// is taken into the first stage.
module half_duplex_serial_poll_sequencer #(
	parameter int FRAME_MAX = hdps_pkg::FRAME_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_ready,
	input  hdps_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output hdps_pkg::rsp_t rsp
);
	import hdps_pkg::*;

	localparam int ADDR_W = $clog2(FRAME_MAX);
	localparam logic [7:0] FRAME_LAST = 8'(FRAME_MAX);

	logic [15:0] send_period_q, turnaround_q, byte_gap_q, no_answer_q;
	logic [2:0]  phase_q;
	logic [15:0] phase_time_q, idle_time_q;
	logic [7:0]  byte_count_q;

	logic        valid_s1, valid_s2;
	logic [2:0]  action_s1, phase_s1;
	logic [7:0]  length_s1;
	logic        rd_s1;
	rsp_t        rsp_s2;

	logic        accept, adv;
	logic [2:0]  phase_n, action_n;
	logic [15:0] phase_time_n, idle_time_n, idle_sum;
	logic [7:0]  byte_count_n;
	logic        wr_en;
	logic [7:0]  mem_rdata;

	assign adv = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || !valid_s2 || rsp_ready;
	assign accept = req_valid && req_ready;
	assign wr_en = accept && (req.op == OP_BYTE) && (phase_q == PH_RECV)
		&& (byte_count_q < FRAME_LAST);
	assign idle_sum = sat_add16(idle_time_q, req.elapsed);

	always_comb begin
		phase_n = phase_q;
		action_n = ACT_NONE;
		idle_time_n = idle_time_q;
		byte_count_n = byte_count_q;
		phase_time_n = phase_time_q;
		case (req.op)
			OP_TICK: begin
				case (phase_q)
					PH_TURN: begin
						if (phase_time_q >= turnaround_q) begin
							phase_n = PH_SEND;
							action_n = ACT_START_TX;
						end
					end
					PH_SEND: begin
						if (!req.tx_busy) begin
							phase_n = PH_RECV;
							byte_count_n = '0;
							action_n = ACT_PREP_RX;
						end
					end
					PH_RECV: begin
						idle_time_n = idle_sum;
						if ((byte_count_q != '0 && idle_sum >= byte_gap_q)
							|| idle_sum > no_answer_q || byte_count_q >= FRAME_LAST) begin
							phase_n = PH_DONE;
							action_n = ACT_STOP_RX;
						end
					end
					PH_DONE: begin
						action_n = ACT_FRAME_RDY;
						idle_time_n = '0;
						phase_n = PH_IDLE;
					end
					default: begin
						phase_n = PH_IDLE;
						if (phase_time_q > send_period_q && req.have_data) begin
							phase_n = PH_TURN;
							action_n = ACT_PREP_TX;
						end
					end
				endcase
				phase_time_n = (phase_n != phase_q) ? req.elapsed
					: sat_add16(phase_time_q, req.elapsed);
			end
			OP_BYTE: begin
				if (phase_q == PH_RECV && byte_count_q < FRAME_LAST) begin
					byte_count_n = byte_count_q + 8'd1;
					idle_time_n = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_period_q <= SEND_PERIOD_RST;
			turnaround_q <= TURNAROUND_RST;
			byte_gap_q <= BYTE_GAP_RST;
			no_answer_q <= NO_ANSWER_RST;
			phase_q <= PH_IDLE;
			phase_time_q <= '0;
			idle_time_q <= '0;
			byte_count_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEND_PERIOD: send_period_q <= cfg_data;
					REG_TURNAROUND: turnaround_q <= cfg_data;
					REG_BYTE_GAP: byte_gap_q <= cfg_data;
					REG_NO_ANSWER: no_answer_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				phase_q <= phase_n;
				phase_time_q <= phase_time_n;
				idle_time_q <= idle_time_n;
				byte_count_q <= byte_count_n;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action_n;
			phase_s1 <= phase_n;
			length_s1 <= byte_count_n;
			rd_s1 <= (req.op == OP_READ);
		end
		if (adv) begin
			rsp_s2.action <= action_s1;
			rsp_s2.frame_length <= length_s1;
			rsp_s2.read_data <= rd_s1 ? mem_rdata : 8'd0;
			rsp_s2.phase <= phase_s1;
		end
	end

	hdps_frame_mem #(
		.ADDR_W(ADDR_W)
	) u_frame_mem (
		.clk(clk),
		.we(wr_en),
		.waddr(byte_count_q[ADDR_W-1:0]),
		.wdata(req.rx_data),
		.re(accept && req.op == OP_READ),
		.raddr(req.read_index[ADDR_W-1:0]),
		.rdata(mem_rdata)
	);

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

`ifndef SYNTH
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE || phase_q == PH_TURN || phase_q == PH_SEND
		|| phase_q == PH_RECV || phase_q == PH_DONE)
		else $error("phase register left the legal set");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= FRAME_LAST)
		else $error("byte count passed the frame limit");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.op == OP_TICK && phase_q == PH_DONE
		|=> phase_q == PH_IDLE && idle_time_q == '0)
		else $error("frame delivery did not return to idle");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost in first stage");
`endif

endmodule

FILE: src/hdps_frame_mem.sv
module hdps_frame_mem #(
	parameter int ADDR_W = hdps_pkg::FRAME_ADDR_W_DEF
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);
	import hdps_pkg::*;

	logic [7:0] mem_q [2**ADDR_W];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: tb/sv/tb_half_duplex_serial_poll_sequencer.sv
`timescale 1ns / 100ps

module tb_half_duplex_serial_poll_sequencer;
	import hdps_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int FRAME_LIMIT = FRAME_MAX_DEF;
	localparam logic [1:0] OP_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_SEND_PERIOD;
	logic [15:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic [15:0] send_period_q = SEND_PERIOD_RST;
	logic [15:0] turnaround_q = TURNAROUND_RST;
	logic [15:0] byte_gap_q = BYTE_GAP_RST;
	logic [15:0] no_answer_q = NO_ANSWER_RST;

	logic [2:0] phase_q = PH_IDLE;
	logic [15:0] phase_time_q = '0;
	logic [15:0] quiet_time_q = '0;
	logic [7:0] byte_count_q = '0;
	logic [7:0] frame_copy [256];
	bit [255:0] written_q = '0;

	req_t poll_queue[$];
	rsp_t status_due[$];
	int send_gap_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int cycles = 0;

	half_duplex_serial_poll_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] clip_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = 17'(a) + 17'(b);
		if (s > 17'h0ffff) return 16'hffff;
		return s[15:0];
	endfunction

	function automatic rsp_t poll_step(input req_t r);
		rsp_t o;
		logic [2:0] prior;
		o = '0;
		case (r.op)
			OP_TICK: begin
				prior = phase_q;
				case (phase_q)
					PH_TURN: begin
						if (phase_time_q >= turnaround_q) begin
							phase_q = PH_SEND;
							o.action = ACT_START_TX;
						end
					end
					PH_SEND: begin
						if (!r.tx_busy) begin
							phase_q = PH_RECV;
							byte_count_q = '0;
							o.action = ACT_PREP_RX;
						end
					end
					PH_RECV: begin
						quiet_time_q = clip_add(quiet_time_q, r.elapsed);
						if ((byte_count_q != 0 && quiet_time_q >= byte_gap_q) ||
							quiet_time_q > no_answer_q || byte_count_q >= FRAME_LIMIT) begin
							phase_q = PH_DONE;
							o.action = ACT_STOP_RX;
						end
					end
					PH_DONE: begin
						o.action = ACT_FRAME_RDY;
						quiet_time_q = '0;
						phase_q = PH_IDLE;
					end
					default: begin
						phase_q = PH_IDLE;
						if (phase_time_q > send_period_q && r.have_data) begin
							phase_q = PH_TURN;
							o.action = ACT_PREP_TX;
						end
					end
				endcase
				if (phase_q != prior) phase_time_q = '0;
				phase_time_q = clip_add(phase_time_q, r.elapsed);
			end
			OP_BYTE: begin
				if (phase_q == PH_RECV && byte_count_q < FRAME_LIMIT) begin
					frame_copy[byte_count_q] = r.rx_data;
					written_q[byte_count_q] = 1'b1;
					byte_count_q = byte_count_q + 8'd1;
					quiet_time_q = '0;
				end
			end
			OP_READ: o.read_data = frame_copy[r.read_index];
			default: ;
		endcase
		o.frame_length = byte_count_q;
		o.phase = phase_q;
		return o;
	endfunction

	// A read may only address an entry that has been written since reset.
	function automatic req_t legal_read(input req_t r);
		logic [7:0] idx;
		idx = r.read_index;
		if (r.op != OP_READ || written_q[idx]) return r;
		for (int k = 0; k < FRAME_LIMIT; k++) begin
			idx = (idx == 8'd254) ? 8'd0 : idx + 8'd1;
			if (written_q[idx]) begin
				r.read_index = idx;
				return r;
			end
		end
		r.op = OP_NOP;
		return r;
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(1));
	endfunction

	function automatic req_t any_request();
		req_t r;
		r.op = 2'($urandom_range(3));
		r.elapsed = coin() ? 16'($urandom_range(65535)) : 16'($urandom_range(15));
		r.have_data = coin();
		r.tx_busy = coin();
		r.rx_data = 8'($urandom_range(255));
		r.read_index = 8'($urandom_range(254));
		return r;
	endfunction

	task automatic push_tick(input logic [15:0] elapsed, input logic have_data,
		input logic tx_busy);
		req_t r;
		r = any_request();
		r.op = OP_TICK;
		r.elapsed = elapsed;
		r.have_data = have_data;
		r.tx_busy = tx_busy;
		poll_queue.push_back(r);
	endtask

	task automatic push_byte(input logic [7:0] value);
		req_t r;
		r = any_request();
		r.op = OP_BYTE;
		r.rx_data = value;
		poll_queue.push_back(r);
	endtask

	task automatic push_read(input logic [7:0] idx);
		req_t r;
		r = any_request();
		r.op = OP_READ;
		r.read_index = idx;
		poll_queue.push_back(r);
	endtask

	// One poll: wait out the send period, turn the line around, send, collect
	// an answer, deliver it and read back up to four stored entries.
	task automatic queue_poll_cycle();
		int nbytes;
		int sel;
		repeat ($urandom_range(2)) push_tick(16'($urandom_range(40)), 1'b0, coin());
		push_tick(clip_add(send_period_q, 16'($urandom_range(1, 3))), coin(), coin());
		push_tick(16'($urandom_range(3)), 1'b1, coin());
		push_tick(coin() ? turnaround_q : 16'($urandom_range(3)), coin(), coin());
		push_tick(16'($urandom_range(3)), coin(), coin());
		repeat ($urandom_range(3)) push_tick(16'($urandom_range(3)), coin(), 1'b1);
		push_tick(16'($urandom_range(3)), coin(), 1'b0);
		sel = $urandom_range(99);
		if (sel < 10) nbytes = 0;
		else if (sel < 16) nbytes = $urandom_range(250, 262);
		else nbytes = $urandom_range(1, 24);
		for (int i = 0; i < nbytes; i++) begin
			push_byte(8'($urandom_range(255)));
			if ($urandom_range(5) == 0) push_tick(16'($urandom_range(3)), coin(), coin());
		end
		if (coin()) push_tick(clip_add(byte_gap_q, 16'($urandom_range(2))), coin(), coin());
		else push_tick(clip_add(no_answer_q, 16'($urandom_range(1, 3))), coin(), coin());
		push_tick(16'($urandom_range(3)), coin(), coin());
		repeat ($urandom_range(4)) push_read(8'($urandom_range(254)));
		if ($urandom_range(3) == 0) poll_queue.push_back(any_request());
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (poll_queue.size() != 0 || req_valid || status_due.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_SEND_PERIOD: send_period_q = value;
			REG_TURNAROUND: turnaround_q = value;
			REG_BYTE_GAP: byte_gap_q = value;
			default: no_answer_q = value;
		endcase
	endtask

	task automatic run_phase(input logic [15:0] sp, input logic [15:0] tw,
		input logic [15:0] gap, input logic [15:0] na, input int gap_pct,
		input int hold_pct, input int budget);
		wait_drained();
		write_reg(REG_SEND_PERIOD, sp);
		write_reg(REG_TURNAROUND, tw);
		write_reg(REG_BYTE_GAP, gap);
		write_reg(REG_NO_ANSWER, na);
		@(posedge clk);
		cfg_we <= 1'b0;
		send_gap_pct = gap_pct;
		stall_pct = hold_pct;
		while (poll_queue.size() < budget) queue_poll_cycle();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) status_due.push_back(poll_step(req));
			if (!req_valid || req_ready) begin
				if (poll_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					req <= legal_read(poll_queue.pop_front());
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_status(input rsp_t got);
		rsp_t want;
		if (status_due.size() == 0) begin
			$display("%0t: response %p arrived with no request outstanding", $time, got);
			errors++;
			return;
		end
		want = status_due.pop_front();
		if (got.action !== want.action) begin
			$display("%0t: action expected %0d, got %0d", $time, want.action, got.action);
			errors++;
		end
		if (got.frame_length !== want.frame_length) begin
			$display("%0t: frame_length expected %0d, got %0d", $time,
				want.frame_length, got.frame_length);
			errors++;
		end
		if (got.read_data !== want.read_data) begin
			$display("%0t: read_data expected %0h, got %0h", $time,
				want.read_data, got.read_data);
			errors++;
		end
		if (got.phase !== want.phase) begin
			$display("%0t: phase expected %0d, got %0d", $time, want.phase, got.phase);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) check_status(rsp);
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		req_t r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		r = any_request();
		r.op = OP_NOP;
		poll_queue.push_back(r);
		push_byte(8'hff);
		push_tick(16'hffff, 1'b0, 1'b1);
		push_tick(16'hffff, 1'b0, 1'b0);
		push_tick(16'd0, 1'b1, 1'b1);
		push_tick(16'd3, 1'b0, 1'b0);
		push_tick(16'd2, 1'b1, 1'b0);
		push_tick(16'd0, 1'b0, 1'b1);
		push_tick(16'd1, 1'b1, 1'b1);
		push_tick(16'd1, 1'b0, 1'b0);
		push_byte(8'h00);
		push_byte(8'hff);
		push_byte(8'ha5);
		push_byte(8'h5a);
		push_tick(16'd4, 1'b1, 1'b0);
		push_tick(16'd1, 1'b0, 1'b1);
		push_byte(8'h3c);
		push_tick(16'd0, 1'b1, 1'b1);
		push_read(8'd0);
		push_read(8'd3);
		push_read(8'd2);
		push_read(8'd200);

		run_phase(16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 150);
		run_phase(16'd20, 16'd3, 16'd4, 16'd30, 85, 0, 220);
		run_phase(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 40);
		run_phase(16'd10, 16'd2, 16'd6, 16'd50, 0, 85, 180);
		run_phase(16'd100, 16'd10, 16'd8, 16'hffff, 19, 19, 180);
		run_phase(16'd40, 16'hffff, 16'hffff, 16'd0, 0, 0, 70);
		run_phase(SEND_PERIOD_RST, TURNAROUND_RST, BYTE_GAP_RST, NO_ANSWER_RST, 0, 0, 190);
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
